FILE: rtl/core/image_frame_deframer_assert.svh
// assertion macros for the image deframer, clocked on clk, held off in reset
`ifndef IMAGE_FRAME_DEFRAMER_ASSERT_SVH
`define IMAGE_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define IFFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define IFFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: rtl/core/iffd_pkg.sv
package iffd_pkg;

    // header layout
    localparam int DIGEST_BYTES = 32;
    localparam int HDR_LEN      = 8 + DIGEST_BYTES;
    localparam int HCNT_W       = $clog2(HDR_LEN + 1);
    localparam int NWORDS_RAW   = (DIGEST_BYTES + 7) / 8;
    localparam int NWORDS       = (NWORDS_RAW > 4) ? 4 : NWORDS_RAW;
    // digest bytes kept in the four stored words
    localparam int STORE_BYTES  = (DIGEST_BYTES > 32) ? 32 : DIGEST_BYTES;

    // timers
    localparam int TICK_W = 22;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // configuration reset values
    localparam logic [31:0]       MAGIC_RESET   = 32'd1296649292;
    localparam logic [TICK_W-1:0] HDR_TO_RESET  = 22'd300000;
    localparam logic [TICK_W-1:0] STALL_RESET   = 22'd20000;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC  = 2'd0;
    localparam logic [1:0] CFG_HDR_TO = 2'd1;
    localparam logic [1:0] CFG_STALL  = 2'd2;

    // request types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BODY   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_DIGEST = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ERR_HDR_TO    = 3'd3;
    localparam logic [2:0] ERR_STALL     = 3'd4;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DIGEST,
        PH_BODY
    } phase_t;

    // one queued result: data carries body byte, size or digest word,
    // flag carries final or have-digest, code carries error or word index
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
        logic        flag;
        logic [2:0]  code;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: rtl/core/iffd_front.sv
module iffd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    rx_byte,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  iffd_pkg::qstat_t              q_stat,
    output iffd_pkg::push_t               q_push
);

    iffd_pkg::phase_t                     phase_reg, phase_next;
    logic [iffd_pkg::HCNT_W-1:0]          hcount_reg, hcount_next;
    logic                                 match_reg, match_next;
    logic [31:0]                          size_reg, size_next;
    logic                                 nonzero_reg, nonzero_next;
    logic [31:0]                          left_reg, left_next;
    logic [iffd_pkg::TICK_W-1:0]          elapsed_reg, elapsed_next;
    logic [1:0]                           wcnt_reg, wcnt_next;
    logic [63:0]                          digest_reg [4];
    logic [63:0]                          digest_next [4];

    logic [31:0]                          magic_reg;
    logic [iffd_pkg::TICK_W-1:0]          hdr_to_reg;
    logic [iffd_pkg::TICK_W-1:0]          stall_reg;

    logic                                 accept;
    logic [iffd_pkg::HCNT_W-1:0]          dpos;
    logic [iffd_pkg::TICK_W-1:0]          tick_inc;
    logic [iffd_pkg::TICK_W-1:0]          limit;
    logic [31:0]                          left_dec;

    // input held while digest words go out or the queue is full
    assign in_stall = (phase_reg == iffd_pkg::PH_DIGEST) || q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign dpos     = hcount_reg - iffd_pkg::HCNT_W'(8);
    assign tick_inc = (elapsed_reg != iffd_pkg::TICK_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign limit    = (phase_reg == iffd_pkg::PH_HEADER) ? hdr_to_reg : stall_reg;
    assign left_dec = left_reg - 32'd1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg  <= iffd_pkg::MAGIC_RESET;
            hdr_to_reg <= iffd_pkg::HDR_TO_RESET;
            stall_reg  <= iffd_pkg::STALL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                iffd_pkg::CFG_MAGIC:  magic_reg  <= cfg_data;
                iffd_pkg::CFG_HDR_TO: hdr_to_reg <= cfg_data[iffd_pkg::TICK_W-1:0];
                iffd_pkg::CFG_STALL:  stall_reg  <= cfg_data[iffd_pkg::TICK_W-1:0];
                default:              ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= iffd_pkg::PH_IDLE;
            hcount_reg  <= '0;
            match_reg   <= 1'b1;
            size_reg    <= '0;
            nonzero_reg <= 1'b0;
            left_reg    <= '0;
            elapsed_reg <= '0;
            wcnt_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hcount_reg  <= hcount_next;
            match_reg   <= match_next;
            size_reg    <= size_next;
            nonzero_reg <= nonzero_next;
            left_reg    <= left_next;
            elapsed_reg <= elapsed_next;
            wcnt_reg    <= wcnt_next;
        end
    end

    // digest words, no reset
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            digest_reg[k] <= digest_next[k];
        end
    end

    // request decode and next state
    always_comb
    begin
        phase_next   = phase_reg;
        hcount_next  = hcount_reg;
        match_next   = match_reg;
        size_next    = size_reg;
        nonzero_next = nonzero_reg;
        left_next    = left_reg;
        elapsed_next = elapsed_reg;
        wcnt_next    = wcnt_reg;
        for (int k = 0; k < 4; k++)
        begin
            digest_next[k] = digest_reg[k];
        end
        q_push       = '0;

        case (phase_reg)
            iffd_pkg::PH_DIGEST:
            begin
                // one digest word per cycle into the queue while the queue is not full
                if (!q_stat.full)
                begin
                    q_push.valid      = 1'b1;
                    q_push.entry.kind = iffd_pkg::KIND_DIGEST;
                    q_push.entry.data = digest_reg[wcnt_reg];
                    q_push.entry.code = {1'b0, wcnt_reg};
                    if (wcnt_reg == 2'(iffd_pkg::NWORDS - 1))
                    begin
                        q_push.entry.last = 1'b1;
                        phase_next        = iffd_pkg::PH_BODY;
                    end
                    wcnt_next = wcnt_reg + 2'd1;
                end
            end
            default:
            begin
                if (accept)
                begin
                    case (req_type)
                        iffd_pkg::REQ_START:
                        begin
                            phase_next   = iffd_pkg::PH_HEADER;
                            hcount_next  = '0;
                            match_next   = 1'b1;
                            size_next    = '0;
                            nonzero_next = 1'b0;
                            left_next    = '0;
                            elapsed_next = '0;
                        end
                        iffd_pkg::REQ_BYTE:
                        begin
                            if (phase_reg == iffd_pkg::PH_HEADER)
                            begin
                                // magic, then size, then digest bytes
                                if (hcount_reg < iffd_pkg::HCNT_W'(4))
                                begin
                                    if (magic_reg[{hcount_reg[1:0], 3'b000} +: 8] != rx_byte)
                                    begin
                                        match_next = 1'b0;
                                    end
                                end
                                else if (hcount_reg < iffd_pkg::HCNT_W'(8))
                                begin
                                    size_next[{hcount_reg[1:0], 3'b000} +: 8] =
                                        size_reg[{hcount_reg[1:0], 3'b000} +: 8] | rx_byte;
                                end
                                else
                                begin
                                    if (rx_byte != 8'd0)
                                    begin
                                        nonzero_next = 1'b1;
                                    end
                                    if (dpos < iffd_pkg::HCNT_W'(iffd_pkg::STORE_BYTES))
                                    begin
                                        if (dpos[2:0] == 3'd0)
                                        begin
                                            digest_next[dpos[4:3]] = {56'd0, rx_byte};
                                        end
                                        else
                                        begin
                                            digest_next[dpos[4:3]][{dpos[2:0], 3'b000} +: 8] =
                                                rx_byte;
                                        end
                                    end
                                end
                                hcount_next = hcount_reg + 1'b1;

                                // header complete
                                if (hcount_next == iffd_pkg::HCNT_W'(iffd_pkg::HDR_LEN))
                                begin
                                    q_push.valid      = 1'b1;
                                    q_push.entry.last = 1'b1;
                                    phase_next        = iffd_pkg::PH_IDLE;
                                    if (!match_next)
                                    begin
                                        q_push.entry.kind = iffd_pkg::KIND_ERROR;
                                        q_push.entry.code = iffd_pkg::ERR_MAGIC;
                                    end
                                    else if (size_next == 32'd0)
                                    begin
                                        q_push.entry.kind = iffd_pkg::KIND_ERROR;
                                        q_push.entry.code = iffd_pkg::ERR_ZERO_SIZE;
                                    end
                                    else
                                    begin
                                        q_push.entry.kind = iffd_pkg::KIND_ACCEPT;
                                        q_push.entry.data = {32'd0, size_next};
                                        q_push.entry.flag = nonzero_next;
                                        q_push.entry.last = 1'b0;
                                        phase_next        = iffd_pkg::PH_DIGEST;
                                        wcnt_next         = '0;
                                        left_next         = size_next;
                                        elapsed_next      = '0;
                                    end
                                end
                            end
                            else if (phase_reg == iffd_pkg::PH_BODY)
                            begin
                                left_next         = left_dec;
                                elapsed_next      = '0;
                                q_push.valid      = 1'b1;
                                q_push.entry.kind = iffd_pkg::KIND_BODY;
                                q_push.entry.data = {56'd0, rx_byte};
                                q_push.entry.flag = (left_dec == 32'd0);
                                q_push.entry.last = 1'b1;
                                if (left_dec == 32'd0)
                                begin
                                    phase_next = iffd_pkg::PH_IDLE;
                                end
                            end
                        end
                        iffd_pkg::REQ_TICK:
                        begin
                            // saturating timer against the phase's limit
                            if (phase_reg == iffd_pkg::PH_HEADER ||
                                phase_reg == iffd_pkg::PH_BODY)
                            begin
                                elapsed_next = tick_inc;
                                if (tick_inc >= limit)
                                begin
                                    q_push.valid      = 1'b1;
                                    q_push.entry.kind = iffd_pkg::KIND_ERROR;
                                    q_push.entry.code = (phase_reg == iffd_pkg::PH_HEADER) ?
                                                        iffd_pkg::ERR_HDR_TO :
                                                        iffd_pkg::ERR_STALL;
                                    q_push.entry.last = 1'b1;
                                    phase_next        = iffd_pkg::PH_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

FILE: rtl/core/iffd_queue.sv
module iffd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  iffd_pkg::push_t   q_push,
    input  logic              q_pop,
    output iffd_pkg::entry_t  q_head,
    output iffd_pkg::qstat_t  q_stat
);

    iffd_pkg::entry_t             mem_reg [iffd_pkg::QDEPTH];
    logic [iffd_pkg::QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [iffd_pkg::QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [iffd_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign q_stat.full  = (count_reg == iffd_pkg::QCNT_W'(iffd_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = q_push.valid && !q_stat.full;
    assign do_pop       = q_pop && !q_stat.empty;
    assign q_head       = mem_reg[rptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= q_push.entry;
        end
    end

endmodule

FILE: rtl/core/iffd_back.sv
module iffd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  iffd_pkg::entry_t  q_head,
    input  iffd_pkg::qstat_t  q_stat,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        data_byte,
    output logic              final_body_byte,
    output logic [31:0]       frame_size,
    output logic              have_digest,
    output logic [63:0]       digest_word,
    output logic [1:0]        digest_index,
    output logic [2:0]        error_code,
    output logic              run_end
);

    logic         valid_reg, valid_next;
    logic [1:0]   kind_reg, kind_next;
    logic [7:0]   data_reg, data_next;
    logic         final_reg, final_next;
    logic [31:0]  size_reg, size_next;
    logic         have_reg, have_next;
    logic [63:0]  word_reg, word_next;
    logic [1:0]   index_reg, index_next;
    logic [2:0]   error_reg, error_next;
    logic         end_reg, end_next;
    logic         load;

    // output register refills when empty or when its beat is taken
    assign load  = !valid_reg || !out_stall;
    assign q_pop = load && !q_stat.empty;

    // entry to result fields, unused fields zero
    always_comb
    begin
        kind_next  = q_head.kind;
        data_next  = (q_head.kind == iffd_pkg::KIND_BODY) ? q_head.data[7:0] : 8'd0;
        final_next = (q_head.kind == iffd_pkg::KIND_BODY) && q_head.flag;
        size_next  = (q_head.kind == iffd_pkg::KIND_ACCEPT) ? q_head.data[31:0] : 32'd0;
        have_next  = (q_head.kind == iffd_pkg::KIND_ACCEPT) && q_head.flag;
        word_next  = (q_head.kind == iffd_pkg::KIND_DIGEST) ? q_head.data : 64'd0;
        index_next = (q_head.kind == iffd_pkg::KIND_DIGEST) ? q_head.code[1:0] : 2'd0;
        error_next = (q_head.kind == iffd_pkg::KIND_ERROR) ? q_head.code : iffd_pkg::ERR_NONE;
        end_next   = q_head.last;
        valid_next = load ? !q_stat.empty : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            final_reg <= final_next;
            size_reg  <= size_next;
            have_reg  <= have_next;
            word_reg  <= word_next;
            index_reg <= index_next;
            error_reg <= error_next;
            end_reg   <= end_next;
        end
    end

    assign out_valid       = valid_reg;
    assign kind            = kind_reg;
    assign data_byte       = data_reg;
    assign final_body_byte = final_reg;
    assign frame_size      = size_reg;
    assign have_digest     = have_reg;
    assign digest_word     = word_reg;
    assign digest_index    = index_reg;
    assign error_code      = error_reg;
    assign run_end         = end_reg;

endmodule

FILE: rtl/core/image_frame_deframer.sv
// Image frame deframer: takes one request beat per cycle when not stalled (start, received byte or
// millisecond tick) and emits header status, digest words, body bytes and errors.
// The byte that completes an accepted header holds the input while the NWORDS
// digest words (four at a 32-byte digest) enter the four-entry result queue; the
// input also stalls whenever that queue is full. Results leave through a registered
// output stage, and configuration writes are always ready.
`include "image_frame_deframer_assert.svh"

module image_frame_deframer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   req_type,
    input  logic [7:0]   rx_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   kind,
    output logic [7:0]   data_byte,
    output logic         final_body_byte,
    output logic [31:0]  frame_size,
    output logic         have_digest,
    output logic [63:0]  digest_word,
    output logic [1:0]   digest_index,
    output logic [2:0]   error_code,
    output logic         run_end,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    iffd_pkg::push_t   q_push;
    iffd_pkg::qstat_t  q_stat;
    iffd_pkg::entry_t  q_head;
    logic              q_pop;

    assign cfg_ready = 1'b1;

    // request decode and header state
    iffd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push)
    );

    // result queue
    iffd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    // output stage
    iffd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_head          (q_head),
        .q_stat          (q_stat),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .data_byte       (data_byte),
        .final_body_byte (final_body_byte),
        .frame_size      (frame_size),
        .have_digest     (have_digest),
        .digest_word     (digest_word),
        .digest_index    (digest_index),
        .error_code      (error_code),
        .run_end         (run_end)
    );

    // a full queue must hold the input
    `IFFD_ASSERT_SAME(a_full_stalls, q_stat.full, in_stall)
    // a queue push is never dropped
    `IFFD_ASSERT_SAME(a_no_drop, q_push.valid, !q_stat.full)
    // an accepted header is always followed by digest words
    `IFFD_ASSERT_SAME(a_accept_not_last, out_valid && kind == iffd_pkg::KIND_ACCEPT, !run_end)
    // body bytes and errors close their request
    `IFFD_ASSERT_SAME(a_single_end,
        out_valid && (kind == iffd_pkg::KIND_BODY || kind == iffd_pkg::KIND_ERROR), run_end)
    // a taken beat with a queue backlog is followed by another beat
    `IFFD_ASSERT_NEXT(a_refill, out_valid && !out_stall && !q_stat.empty, out_valid)

endmodule
